FILE: sv/gbc_pkg.sv
// gbc_pkg: shared constants, types and round functions for gost_block_cipher
// substitution rows, key schedule selection and the single feistel round
// no dependencies
package gbc_pkg;

	localparam int unsigned NUM_ROUNDS = 32;
	localparam int unsigned KEY_WORDS  = 8;
	localparam int unsigned ROT_AMOUNT = 11;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned BLOCK_W    = 64;
	localparam int unsigned CFG_IDX_W  = 4;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [BLOCK_W-1:0] block_t;
	typedef logic [2:0]         key_idx_t;
	typedef logic [4:0]         round_idx_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	typedef logic [3:0] nib_t;
	typedef nib_t sbox_row_t [16];
	typedef sbox_row_t sbox_t [8];

	localparam sbox_t SBOX = '{
		'{4'h5, 4'h9, 4'h2, 4'h4, 4'h8, 4'h7, 4'h3, 4'hA,
		  4'hF, 4'h1, 4'hD, 4'hB, 4'h6, 4'hE, 4'h0, 4'hC},
		'{4'h7, 4'hD, 4'h5, 4'hC, 4'h2, 4'hE, 4'h4, 4'h3,
		  4'h0, 4'h8, 4'hA, 4'h9, 4'h1, 4'h6, 4'hB, 4'hF},
		'{4'hC, 4'h9, 4'hB, 4'h4, 4'hF, 4'h5, 4'hA, 4'h1,
		  4'hE, 4'h3, 4'h7, 4'hD, 4'h8, 4'h6, 4'h0, 4'h2},
		'{4'hA, 4'h8, 4'h4, 4'h0, 4'h6, 4'hF, 4'hB, 4'h3,
		  4'hC, 4'hD, 4'h2, 4'h1, 4'h7, 4'h5, 4'h9, 4'hE},
		'{4'h8, 4'hA, 4'hF, 4'h6, 4'h9, 4'hB, 4'h4, 4'hC,
		  4'h7, 4'h1, 4'h3, 4'h5, 4'h0, 4'h0, 4'h2, 4'hD},
		'{4'hD, 4'h1, 4'hA, 4'h0, 4'h5, 4'h8, 4'h2, 4'hE,
		  4'h7, 4'hF, 4'h9, 4'hC, 4'hB, 4'h3, 4'h6, 4'h4},
		'{4'hF, 4'h7, 4'h6, 4'hA, 4'hC, 4'h4, 4'h1, 4'hB,
		  4'hE, 4'h9, 4'h8, 4'h0, 4'h2, 4'h5, 4'hD, 4'h3},
		'{4'hF, 4'h7, 4'h6, 4'hA, 4'hC, 4'h4, 4'h1, 4'hB,
		  4'hE, 4'h9, 4'h8, 4'h0, 4'h2, 4'h5, 4'hD, 4'h3}
	};

	// row 0 serves the most significant nibble
	function automatic word_t substitute(input word_t w);
		word_t res;
		res = '0;
		for (int p = 0; p < 8; p++) begin
			res[(28 - 4*p) +: 4] = SBOX[p][w[(28 - 4*p) +: 4]];
		end
		return res;
	endfunction

	function automatic word_t rotl(input word_t w);
		return (w << ROT_AMOUNT) | (w >> (WORD_W - ROT_AMOUNT));
	endfunction

	// feistel output word: substitute(right + key) rotated, xor left
	function automatic word_t round_f(input word_t left, input word_t right, input word_t key);
		word_t sum;
		sum = right + key;
		return rotl(substitute(sum)) ^ left;
	endfunction

	// encrypt: forward passes 0..2, reverse pass 3
	// decrypt: forward pass 0, reverse passes 1..3
	function automatic key_idx_t key_sel(input round_idx_t rnd, input logic enc);
		logic [1:0] pass;
		logic       rev;
		pass = rnd[4:3];
		rev  = (pass == 2'd3) || (!enc && (pass != 2'd0));
		return rev ? ~rnd[2:0] : rnd[2:0];
	endfunction

endpackage

FILE: sv/gost_block_cipher.sv
// gost_block_cipher: 32-round feistel block cipher, ecb, one round per stage
// depends on gbc_pkg for the substitution table and round functions
//
// channel  | handshake            | payload
// in       | in_valid / in_ready  | action, block_in
// out      | out_valid / out_ready| block_out
// cfg      | cfg_we               | cfg_idx, cfg_wdata (key words 0..7)
//
// one item per cycle sustained while the output is not stalled
// each of the 32 stages holds one round: add, substitute, rotate, xor
// the whole pipeline advances together when the last stage is empty or taken
// reset clears stage valid bits and key words; payload stages are not reset
module gost_block_cipher (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            action,
	input  gbc_pkg::block_t block_in,
	output logic            out_valid,
	input  logic            out_ready,
	output gbc_pkg::block_t block_out,
	input  logic            cfg_we,
	input  gbc_pkg::cfg_idx_t cfg_idx,
	input  gbc_pkg::word_t  cfg_wdata
);
	import gbc_pkg::*;

	word_t key_q [KEY_WORDS];

	// index k is the register after round k-1 (rounds count from 0)
	word_t l_s   [1:NUM_ROUNDS];
	word_t r_s   [1:NUM_ROUNDS];
	logic  enc_s [1:NUM_ROUNDS];
	logic [NUM_ROUNDS:1] vld_s;

	// round k input: the ports for round 0, else the register after round k-1
	word_t l_in  [NUM_ROUNDS];
	word_t r_in  [NUM_ROUNDS];
	logic  e_in  [NUM_ROUNDS];

	word_t r_nxt [NUM_ROUNDS];
	logic  adv;

	assign adv      = !vld_s[NUM_ROUNDS] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_idx < CFG_IDX_W'(KEY_WORDS))) begin
			key_q[cfg_idx[2:0]] <= cfg_wdata;
		end
	end

	always_comb begin
		l_in[0] = block_in[BLOCK_W-1:WORD_W];
		r_in[0] = block_in[WORD_W-1:0];
		e_in[0] = action;
		for (int k = 1; k < NUM_ROUNDS; k++) begin
			l_in[k] = l_s[k];
			r_in[k] = r_s[k];
			e_in[k] = enc_s[k];
		end
		for (int k = 0; k < NUM_ROUNDS; k++) begin
			r_nxt[k] = round_f(l_in[k], r_in[k], key_q[key_sel(round_idx_t'(k), e_in[k])]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NUM_ROUNDS-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_ROUNDS; k++) begin
				l_s[k+1]   <= r_in[k];
				r_s[k+1]   <= r_nxt[k];
				enc_s[k+1] <= e_in[k];
			end
		end
	end

	// final half swap
	assign out_valid = vld_s[NUM_ROUNDS];
	assign block_out = {r_s[NUM_ROUNDS], l_s[NUM_ROUNDS]};

	a_stall_holds_valids: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("stage valids moved during stall");

	a_entry_valid: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (vld_s[1] == $past(in_valid)))
		else $error("stage 1 valid does not follow accepted input");

	a_bad_cfg_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_idx >= CFG_IDX_W'(KEY_WORDS))) |=>
		($stable(key_q[0]) && $stable(key_q[7])))
		else $error("out-of-range config write changed a key word");

endmodule
